/* hw/rtl/dcfp_pkg.sv */
// shared types, constants and matcher functions for the delimited command frame parser
package dcfp_pkg;

  localparam int FRAME_LIMIT = 80;
  localparam int COUNT_W = 7;

  localparam logic [7:0] START_RESET = 8'h24;
  localparam logic [7:0] END_RESET = 8'h40;

  localparam logic [1:0] ON_LEN = 2'd2;
  localparam logic [1:0] OFF_LEN = 2'd3;
  localparam logic [3:0] READ_LEN = 4'd11;

  typedef enum logic {
    CFG_START_CHAR = 1'b0,
    CFG_END_CHAR   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    cmd_t command;
    logic relay_on;
    logic overflowed;
  } result_t;

  function automatic logic [7:0] on_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h4f;
      2'd1: ch = 8'h4e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] off_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h4f;
      2'd1: ch = 8'h46;
      2'd2: ch = 8'h46;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] read_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0: ch = 8'h52;
      4'd1: ch = 8'h65;
      4'd2: ch = 8'h61;
      4'd3: ch = 8'h64;
      4'd4: ch = 8'h20;
      4'd5: ch = 8'h53;
      4'd6: ch = 8'h65;
      4'd7: ch = 8'h6e;
      4'd8: ch = 8'h73;
      4'd9: ch = 8'h6f;
      4'd10: ch = 8'h72;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // returns {hit, next progress}; no partial-match fallback beyond the first char
  function automatic logic [4:0] match_step(input logic [3:0] prog, input logic [3:0] len,
                                            input logic [7:0] at_prog, input logic [7:0] first,
                                            input logic [7:0] ch);
    logic [3:0] p;
    logic hit;
    if (prog < len && at_prog == ch) begin
      p = prog + 4'd1;
    end else if (first == ch) begin
      p = 4'd1;
    end else begin
      p = 4'd0;
    end
    hit = (p == len);
    if (hit) begin
      p = 4'd0;
    end
    return {hit, p};
  endfunction

endpackage

/* hw/rtl/dcfp_core.sv */
// frame state, substring matchers and command decision for one byte
module dcfp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        start_char,
  input  logic [7:0]        end_char,
  output dcfp_pkg::result_t result
);

  logic                             in_frame, in_frame_next;
  logic [dcfp_pkg::COUNT_W-1:0]     frame_count, frame_count_next;
  logic [1:0]                       on_progress, on_progress_next;
  logic [1:0]                       off_progress, off_progress_next;
  logic [3:0]                       read_progress, read_progress_next;
  logic [2:0]                       found_flags, found_flags_next;
  logic                             relay_level, relay_level_next;

  always_comb begin
    logic [4:0] m_on;
    logic [4:0] m_off;
    logic [4:0] m_read;
    in_frame_next      = in_frame;
    frame_count_next   = frame_count;
    on_progress_next   = on_progress;
    off_progress_next  = off_progress;
    read_progress_next = read_progress;
    found_flags_next   = found_flags;
    relay_level_next   = relay_level;
    result.frame_done  = 1'b0;
    result.command     = dcfp_pkg::CMD_NONE;
    result.overflowed  = 1'b0;
    m_on   = '0;
    m_off  = '0;
    m_read = '0;

    if (rx_byte == start_char) begin
      in_frame_next      = 1'b1;
      frame_count_next   = '0;
      on_progress_next   = '0;
      off_progress_next  = '0;
      read_progress_next = '0;
      found_flags_next   = '0;
    end

    if (in_frame_next) begin
      if (frame_count_next >= dcfp_pkg::COUNT_W'(dcfp_pkg::FRAME_LIMIT)) begin
        frame_count_next   = '0;
        on_progress_next   = '0;
        off_progress_next  = '0;
        read_progress_next = '0;
        found_flags_next   = '0;
        result.overflowed  = 1'b1;
      end else if (rx_byte == end_char) begin
        result.frame_done = 1'b1;
        if (found_flags_next[0]) begin
          result.command   = dcfp_pkg::CMD_ON;
          relay_level_next = 1'b1;
        end else if (found_flags_next[1]) begin
          result.command   = dcfp_pkg::CMD_OFF;
          relay_level_next = 1'b0;
        end else if (found_flags_next[2]) begin
          result.command = dcfp_pkg::CMD_READ;
        end
        in_frame_next      = 1'b0;
        frame_count_next   = '0;
        on_progress_next   = '0;
        off_progress_next  = '0;
        read_progress_next = '0;
        found_flags_next   = '0;
      end else begin
        frame_count_next = frame_count_next + 1'b1;
        m_on = dcfp_pkg::match_step({2'b00, on_progress_next}, {2'b00, dcfp_pkg::ON_LEN},
                                    dcfp_pkg::on_char(on_progress_next),
                                    dcfp_pkg::on_char(2'd0), rx_byte);
        m_off = dcfp_pkg::match_step({2'b00, off_progress_next}, {2'b00, dcfp_pkg::OFF_LEN},
                                     dcfp_pkg::off_char(off_progress_next),
                                     dcfp_pkg::off_char(2'd0), rx_byte);
        m_read = dcfp_pkg::match_step(read_progress_next, dcfp_pkg::READ_LEN,
                                      dcfp_pkg::read_char(read_progress_next),
                                      dcfp_pkg::read_char(4'd0), rx_byte);
        on_progress_next   = m_on[1:0];
        off_progress_next  = m_off[1:0];
        read_progress_next = m_read[3:0];
        found_flags_next   = found_flags_next | {m_read[4], m_off[4], m_on[4]};
      end
    end
    result.relay_on = relay_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      frame_count   <= '0;
      on_progress   <= '0;
      off_progress  <= '0;
      read_progress <= '0;
      found_flags   <= '0;
      relay_level   <= 1'b0;
    end else if (advance) begin
      in_frame      <= in_frame_next;
      frame_count   <= frame_count_next;
      on_progress   <= on_progress_next;
      off_progress  <= off_progress_next;
      read_progress <= read_progress_next;
      found_flags   <= found_flags_next;
      relay_level   <= relay_level_next;
    end
  end

`ifndef ASSERT_OFF
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> frame_count == '0)
    else $error("frame count not clear outside a frame");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    frame_count <= dcfp_pkg::COUNT_W'(dcfp_pkg::FRAME_LIMIT))
    else $error("frame count beyond limit");

  a_cmd_needs_done: assert property (@(posedge clk) disable iff (rst)
    result.command != dcfp_pkg::CMD_NONE |-> result.frame_done)
    else $error("command without frame close");

  a_on_sets_relay: assert property (@(posedge clk) disable iff (rst)
    advance && result.command == dcfp_pkg::CMD_ON |=> relay_level)
    else $error("on command did not set relay");
`endif

endmodule

/* hw/rtl/delimited_command_frame_parser.sv */
// top level of the delimited command frame parser: handshake, config and result registers
//
// rx channel: rx_valid, rx_byte in, rx_stall out. A byte is taken at a rising edge with
// rx_valid high and rx_stall low. Every byte taken gives exactly one result request on the
// res channel: frame_done, command, relay_on and overflowed with res_valid, held while
// res_stall is high and taken at an edge with res_valid high and res_stall low.
// The byte first lands in an input register; the frame state and the three matchers then
// update and the result is captured in the output register. One byte per cycle is
// sustained while the receiver keeps res_stall low. When the receiver stalls, the output
// register holds its result, the input register holds at most one more byte, and rx_stall
// rises only once both are full.
// Config: cfg_write high at a rising edge writes cfg_data into start_char (index 0) or
// end_char (index 1); write only while no request is in flight.
// Reset (rst, synchronous, active high) closes any frame, clears the relay level, empties
// both registers and restores start_char to '$' and end_char to '@'.
module delimited_command_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       frame_done,
  output logic [1:0] command,
  output logic       relay_on,
  output logic       overflowed
);

  logic [7:0]        start_char;
  logic [7:0]        end_char;
  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              out_ready;
  logic              advance;
  logic              rx_take;
  dcfp_pkg::result_t result;
  dcfp_pkg::result_t res_reg;

  assign out_ready = !res_valid || !res_stall;
  assign advance   = hold_valid && out_ready;
  assign rx_stall  = hold_valid && !out_ready;
  assign rx_take   = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= dcfp_pkg::START_RESET;
      end_char   <= dcfp_pkg::END_RESET;
    end else if (cfg_write) begin
      case (dcfp_pkg::cfg_index_t'(cfg_index))
        dcfp_pkg::CFG_START_CHAR: start_char <= cfg_data;
        dcfp_pkg::CFG_END_CHAR:   end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      hold_byte <= rx_byte;
    end
  end

  dcfp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .rx_byte    (hold_byte),
    .start_char (start_char),
    .end_char   (end_char),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= result;
    end
  end

  assign frame_done = res_reg.frame_done;
  assign command    = res_reg.command;
  assign relay_on   = res_reg.relay_on;
  assign overflowed = res_reg.overflowed;

`ifndef ASSERT_OFF
  a_no_done_and_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(frame_done && overflowed))
    else $error("frame close and overflow in one result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> hold_valid && res_valid)
    else $error("input stalled with room to spare");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("advanced byte gave no result");
`endif

endmodule
